// ===== hdl/yhr_pkg.sv =====
// Shared types, widths and coefficient tables for the YIQ hue rotation pipeline.
package yhr_pkg;

    localparam int COEF_FRAC_BITS  = 14;
    localparam int ANGLE_FRAC_BITS = 14;
    localparam int KEEP_FRAC_BITS  = 8;

    localparam int PIX_W  = 8;
    localparam int ANG_W  = 16;
    localparam int COEF_W = COEF_FRAC_BITS + 2;
    localparam int YIQ_W  = 18;
    localparam int ROT_W  = ANG_W + YIQ_W + 1 - ANGLE_FRAC_BITS;
    localparam int NSTG   = 6;

    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 3;

    typedef enum logic {
        REG_COS = 1'b0,
        REG_SIN = 1'b1
    } t_reg_idx;

    typedef logic signed [COEF_W-1:0] t_coef;

    typedef struct packed {
        logic [PIX_W-1:0] red_in;
        logic [PIX_W-1:0] green_in;
        logic [PIX_W-1:0] blue_in;
    } t_pix_in;

    typedef struct packed {
        logic [PIX_W-1:0] red_out;
        logic [PIX_W-1:0] green_out;
        logic [PIX_W-1:0] blue_out;
    } t_pix_out;

    typedef struct packed {
        logic signed [ANG_W-1:0] cos_angle;
        logic signed [ANG_W-1:0] sin_angle;
    } t_angle;

    typedef struct packed {
        logic signed [YIQ_W-1:0] y;
        logic signed [YIQ_W-1:0] i;
        logic signed [YIQ_W-1:0] q;
    } t_yiq;

    typedef struct packed {
        logic signed [ROT_W-1:0] y;
        logic signed [ROT_W-1:0] i;
        logic signed [ROT_W-1:0] q;
    } t_rot;

    typedef struct packed {
        logic mul;
        logic sum;
    } t_stage_en;

    // thousandths to signed fixed point, ties away from zero
    function automatic t_coef milli_to_coef(input int m);
        longint n;
        longint r;
        n = longint'(m) * (longint'(1) <<< COEF_FRAC_BITS);
        if (n >= 0) begin
            r = (n + 500) / 1000;
        end else begin
            r = -((-n + 500) / 1000);
        end
        return COEF_W'(r);
    endfunction

    localparam t_coef YIQ_COEF [3][3] = '{
        '{milli_to_coef(299),  milli_to_coef(587),  milli_to_coef(114)},
        '{milli_to_coef(596),  milli_to_coef(-274), milli_to_coef(-321)},
        '{milli_to_coef(211),  milli_to_coef(-523), milli_to_coef(311)}
    };

    localparam t_coef RGB_COEF [3][3] = '{
        '{milli_to_coef(1000), milli_to_coef(956),   milli_to_coef(621)},
        '{milli_to_coef(1000), milli_to_coef(-272),  milli_to_coef(-647)},
        '{milli_to_coef(1000), milli_to_coef(-1107), milli_to_coef(1705)}
    };

endpackage

// ===== hdl/yiq_hue_rotate_pixel.sv =====
// Top level of the YIQ hue rotation pixel pipeline.
//
//   channel   direction  handshake           payload
//   pixel in  input      i_valid / o_stall   i_pixel (t_pix_in)
//   pixel out output     o_valid / i_stall   o_pixel (t_pix_out)
//   config    input      APB psel/penable    cos_angle @0x0, sin_angle @0x4
//
// Six register stages: multiply and sum/round for each of the three matrices.
// One item per cycle sustained while the output is not stalled (i_stall low).
// Synchronous active-low reset clears the valid bits and loads the identity angle.
// Each stage holds only when it is full and the stage after it holds, so
// empty slots are squeezed out under i_stall.
module yiq_hue_rotate_pixel (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  yhr_pkg::t_pix_in               i_pixel,
    output logic                           o_valid,
    input  logic                           i_stall,
    output yhr_pkg::t_pix_out              o_pixel,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [yhr_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [yhr_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [yhr_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready
);
    import yhr_pkg::*;

    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] w_en;
    t_angle          w_angle;
    t_yiq            w_yiq;
    t_rot            w_rot;
    t_stage_en       w_en_yiq;
    t_stage_en       w_en_rot;
    t_stage_en       w_en_rgb;

    always_comb begin
        w_en[NSTG-1] = !r_vld[NSTG-1] || !i_stall;
        for (int k = NSTG - 2; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign o_stall = !w_en[0];
    assign o_valid = r_vld[NSTG-1];

    assign w_en_yiq = '{mul: w_en[0], sum: w_en[1]};
    assign w_en_rot = '{mul: w_en[2], sum: w_en[3]};
    assign w_en_rgb = '{mul: w_en[4], sum: w_en[5]};

    yhr_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_angle (w_angle)
    );

    yhr_to_yiq u_to_yiq (
        .i_clk   (i_clk),
        .i_en    (w_en_yiq),
        .i_pixel (i_pixel),
        .o_yiq   (w_yiq)
    );

    yhr_rotate u_rotate (
        .i_clk   (i_clk),
        .i_en    (w_en_rot),
        .i_angle (w_angle),
        .i_yiq   (w_yiq),
        .o_rot   (w_rot)
    );

    yhr_to_rgb u_to_rgb (
        .i_clk   (i_clk),
        .i_en    (w_en_rgb),
        .i_rot   (w_rot),
        .o_pixel (o_pixel)
    );

    // input holds only when every stage is occupied and the output is held
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (i_stall && (r_vld == '1)))
        else $error("input stalled with an empty slot in the pipeline");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_vld[0])
        else $error("accepted item did not enter the first stage");

    a_out_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_pixel)))
        else $error("held output item lost or changed under stall");

endmodule

// ===== hdl/yhr_apb_regs.sv =====
// APB register block holding the cosine and sine of the rotation angle.
module yhr_apb_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [yhr_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [yhr_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [yhr_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready,
    output yhr_pkg::t_angle                o_angle
);
    import yhr_pkg::*;

    t_angle   r_angle;
    t_reg_idx w_idx;
    logic     w_wr;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[2]);
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angle.cos_angle <= ANG_W'(1 <<< ANGLE_FRAC_BITS);
            r_angle.sin_angle <= '0;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_COS: r_angle.cos_angle <= pwdata[ANG_W-1:0];
                REG_SIN: r_angle.sin_angle <= pwdata[ANG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_COS: prdata = CFG_DATA_W'(r_angle.cos_angle);
            REG_SIN: prdata = CFG_DATA_W'(r_angle.sin_angle);
            default: prdata = '0;
        endcase
    end

    assign o_angle = r_angle;

endmodule

// ===== hdl/yhr_to_yiq.sv =====
// RGB to YIQ matrix: product stage, then sum and round stage.
module yhr_to_yiq (
    input  logic               i_clk,
    input  yhr_pkg::t_stage_en i_en,
    input  yhr_pkg::t_pix_in   i_pixel,
    output yhr_pkg::t_yiq      o_yiq
);
    import yhr_pkg::*;

    localparam int P_W   = COEF_W + PIX_W + 1;
    localparam int S_W   = P_W + 2;
    localparam int SHIFT = COEF_FRAC_BITS - KEEP_FRAC_BITS;
    localparam logic signed [S_W-1:0] HALF = S_W'(1 <<< (SHIFT - 1));

    logic [PIX_W-1:0]        w_pix  [3];
    logic signed [P_W-1:0]   r_prod [3][3];
    logic signed [S_W-1:0]   w_sum  [3];
    logic signed [YIQ_W-1:0] w_rnd  [3];
    t_yiq                    r_yiq;

    assign w_pix[0] = i_pixel.red_in;
    assign w_pix[1] = i_pixel.green_in;
    assign w_pix[2] = i_pixel.blue_in;

    always_ff @(posedge i_clk) begin
        if (i_en.mul) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r_prod[r][c] <= P_W'(YIQ_COEF[r][c] * $signed({1'b0, w_pix[c]}));
                end
            end
        end
    end

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            w_sum[r] = S_W'(r_prod[r][0]) + S_W'(r_prod[r][1]) + S_W'(r_prod[r][2]) + HALF;
            w_rnd[r] = YIQ_W'(w_sum[r] >>> SHIFT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.sum) begin
            r_yiq.y <= w_rnd[0];
            r_yiq.i <= w_rnd[1];
            r_yiq.q <= w_rnd[2];
        end
    end

    assign o_yiq = r_yiq;

endmodule

// ===== hdl/yhr_rotate.sv =====
// Rotation of the I/Q pair by the programmed angle; Y is carried along.
module yhr_rotate (
    input  logic               i_clk,
    input  yhr_pkg::t_stage_en i_en,
    input  yhr_pkg::t_angle    i_angle,
    input  yhr_pkg::t_yiq      i_yiq,
    output yhr_pkg::t_rot      o_rot
);
    import yhr_pkg::*;

    localparam int P_W = ANG_W + YIQ_W;
    localparam int S_W = P_W + 1;
    localparam logic signed [S_W-1:0] HALF = S_W'(1 <<< (ANGLE_FRAC_BITS - 1));

    logic signed [P_W-1:0]   r_ci;
    logic signed [P_W-1:0]   r_sq;
    logic signed [P_W-1:0]   r_si;
    logic signed [P_W-1:0]   r_cq;
    logic signed [YIQ_W-1:0] r_y;
    logic signed [S_W-1:0]   w_sum_i;
    logic signed [S_W-1:0]   w_sum_q;
    t_rot                    r_rot;

    always_ff @(posedge i_clk) begin
        if (i_en.mul) begin
            r_ci <= P_W'(i_angle.cos_angle * i_yiq.i);
            r_sq <= P_W'(i_angle.sin_angle * i_yiq.q);
            r_si <= P_W'(i_angle.sin_angle * i_yiq.i);
            r_cq <= P_W'(i_angle.cos_angle * i_yiq.q);
            r_y  <= i_yiq.y;
        end
    end

    assign w_sum_i = S_W'(r_ci) - S_W'(r_sq) + HALF;
    assign w_sum_q = S_W'(r_si) + S_W'(r_cq) + HALF;

    always_ff @(posedge i_clk) begin
        if (i_en.sum) begin
            r_rot.y <= ROT_W'(r_y);
            r_rot.i <= ROT_W'(w_sum_i >>> ANGLE_FRAC_BITS);
            r_rot.q <= ROT_W'(w_sum_q >>> ANGLE_FRAC_BITS);
        end
    end

    assign o_rot = r_rot;

endmodule

// ===== hdl/yhr_to_rgb.sv =====
// YIQ to RGB matrix with rounding, clamp and output register.
module yhr_to_rgb (
    input  logic               i_clk,
    input  yhr_pkg::t_stage_en i_en,
    input  yhr_pkg::t_rot      i_rot,
    output yhr_pkg::t_pix_out  o_pixel
);
    import yhr_pkg::*;

    localparam int P_W = COEF_W + ROT_W;
    localparam int S_W = P_W + 2;
    localparam logic signed [S_W-1:0] HALF   = S_W'(1 <<< (COEF_FRAC_BITS - 1));
    localparam logic signed [S_W-1:0] CLAMP  = S_W'(((1 <<< PIX_W) - 1) <<< KEEP_FRAC_BITS);
    localparam logic [PIX_W-1:0]      PIX_MAX = '1;

    logic signed [ROT_W-1:0] w_rot  [3];
    logic signed [P_W-1:0]   r_prod [3][3];
    logic signed [S_W-1:0]   w_sum  [3];
    logic signed [S_W-1:0]   w_rnd  [3];
    logic [PIX_W-1:0]        w_chan [3];
    t_pix_out                r_pixel;

    assign w_rot[0] = i_rot.y;
    assign w_rot[1] = i_rot.i;
    assign w_rot[2] = i_rot.q;

    always_ff @(posedge i_clk) begin
        if (i_en.mul) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r_prod[r][c] <= P_W'(RGB_COEF[r][c] * w_rot[c]);
                end
            end
        end
    end

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            w_sum[r] = S_W'(r_prod[r][0]) + S_W'(r_prod[r][1]) + S_W'(r_prod[r][2]) + HALF;
            w_rnd[r] = w_sum[r] >>> COEF_FRAC_BITS;
            if (w_rnd[r] < 0) begin
                w_chan[r] = '0;
            end else if (w_rnd[r] > CLAMP) begin
                w_chan[r] = PIX_MAX;
            end else begin
                w_chan[r] = w_rnd[r][KEEP_FRAC_BITS +: PIX_W];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.sum) begin
            r_pixel.red_out   <= w_chan[0];
            r_pixel.green_out <= w_chan[1];
            r_pixel.blue_out  <= w_chan[2];
        end
    end

    assign o_pixel = r_pixel;

endmodule

// ===== tb/sv/testbench.sv =====
// Testbench for the YIQ hue rotation pixel pipeline: self-checking against a fixed-point predictor.
`timescale 1ns / 1ps

module testbench;
    import yhr_pkg::*;

    localparam int RUN_LIMIT  = 300000;
    localparam int PIPE_DEPTH = 6;
    localparam int PHASE_PIX  = 160;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    t_pix_in               i_pixel = '0;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    t_pix_out              o_pixel;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [CFG_DATA_W-1:0] pwdata = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    t_pix_in  pix_backlog[$];
    t_pix_out rotated_due[$];
    t_pix_out due_pix;
    int       queued_cnt = 0;
    int       fed_cnt = 0;
    int       mismatch_cnt = 0;
    int       cycle_cnt = 0;
    logic     pix_taken = 1'b0;
    int       burst_left = 0;
    int       idle_gap = 0;
    int       stall_mode = 0;
    int       stall_left = 0;
    longint   cos_q = 16384;
    longint   sin_q = 0;

    yiq_hue_rotate_pixel dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_pixel (i_pixel),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_pixel (o_pixel),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #1 i_clk = ~i_clk;

    function automatic longint fix_coef(int milli);
        longint n;
        n = longint'(milli) * (longint'(1) <<< COEF_FRAC_BITS);
        if (n >= 0) begin
            return (n + 500) / 1000;
        end else begin
            return -((-n + 500) / 1000);
        end
    endfunction

    // round to nearest, ties up; arithmetic shift floors
    function automatic longint round_off(longint v, int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic logic [PIX_W-1:0] clamp_chan(longint v);
        if (v < 0) begin
            return '0;
        end else if (v > (longint'(255) <<< KEEP_FRAC_BITS)) begin
            return 8'd255;
        end else begin
            return PIX_W'(v >>> KEEP_FRAC_BITS);
        end
    endfunction

    function automatic t_pix_out hue_rotate(t_pix_in p);
        int       yiq_milli [3][3];
        int       rgb_milli [3][3];
        longint   rgb [3];
        longint   yiq [3];
        longint   rot [3];
        longint   acc;
        logic [PIX_W-1:0] chan [3];
        t_pix_out res;
        yiq_milli = '{'{299, 587, 114}, '{596, -274, -321}, '{211, -523, 311}};
        rgb_milli = '{'{1000, 956, 621}, '{1000, -272, -647}, '{1000, -1107, 1705}};
        rgb[0] = longint'(p.red_in);
        rgb[1] = longint'(p.green_in);
        rgb[2] = longint'(p.blue_in);
        for (int r = 0; r < 3; r++) begin
            acc = 0;
            for (int c = 0; c < 3; c++) begin
                acc += fix_coef(yiq_milli[r][c]) * rgb[c];
            end
            yiq[r] = round_off(acc, COEF_FRAC_BITS - KEEP_FRAC_BITS);
        end
        rot[0] = yiq[0];
        rot[1] = round_off(cos_q * yiq[1] - sin_q * yiq[2], ANGLE_FRAC_BITS);
        rot[2] = round_off(sin_q * yiq[1] + cos_q * yiq[2], ANGLE_FRAC_BITS);
        for (int r = 0; r < 3; r++) begin
            acc = 0;
            for (int c = 0; c < 3; c++) begin
                acc += fix_coef(rgb_milli[r][c]) * rot[c];
            end
            chan[r] = clamp_chan(round_off(acc, COEF_FRAC_BITS));
        end
        res.red_out   = chan[0];
        res.green_out = chan[1];
        res.blue_out  = chan[2];
        return res;
    endfunction

    function automatic logic [PIX_W-1:0] pick_chan(int mode, logic [PIX_W-1:0] base);
        case (mode)
            0: return base;
            1: return $urandom_range(0, 1) ? 8'd255 : 8'd0;
            2: return PIX_W'($urandom_range(0, 3)) ^ ($urandom_range(0, 1) ? 8'd255 : 8'd0);
            default: return PIX_W'($urandom);
        endcase
    endfunction

    // gray, primary-corner, near-extreme and uniform pixels
    function automatic t_pix_in pick_pixel();
        int               mode;
        logic [PIX_W-1:0] base;
        t_pix_in          p;
        mode = $urandom_range(0, 6);
        base = PIX_W'($urandom);
        p.red_in   = pick_chan(mode, base);
        p.green_in = pick_chan(mode, base);
        p.blue_in  = pick_chan(mode, base);
        return p;
    endfunction

    task automatic note_mismatch(string what, int want, int got);
        mismatch_cnt++;
        if (mismatch_cnt <= 10) begin
            $display("mismatch %s: expected %0d got %0d (item %0d)", what, want, got, fed_cnt);
        end
    endtask

    task automatic queue_pixel(logic [PIX_W-1:0] r, logic [PIX_W-1:0] g, logic [PIX_W-1:0] b);
        t_pix_in p;
        p.red_in   = r;
        p.green_in = g;
        p.blue_in  = b;
        pix_backlog.push_back(p);
        queued_cnt++;
    endtask

    task automatic drain_pipe();
        while (fed_cnt != queued_cnt || rotated_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (PIPE_DEPTH + 4) @(posedge i_clk);
    endtask

    task automatic set_angle(t_reg_idx idx, logic [ANG_W-1:0] val);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = CFG_ADDR_W'(int'(idx) * 4);
        pwdata  = {{(CFG_DATA_W - ANG_W){val[ANG_W-1]}}, val};
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_COS: cos_q = longint'($signed(val));
            REG_SIN: sin_q = longint'($signed(val));
        endcase
        @(negedge i_clk);
        penable = 1'b0;
        pwrite  = 1'b0;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata[ANG_W-1:0] !== val) begin
            note_mismatch("register readback", int'(val), int'(prdata[ANG_W-1:0]));
        end
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // sender: bursts with gaps, payload held while stalled
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (i_valid && !pix_taken) begin
        end else if (idle_gap > 0) begin
            i_valid  <= 1'b0;
            idle_gap <= idle_gap - 1;
        end else if (pix_backlog.size() > 0) begin
            i_valid <= 1'b1;
            i_pixel <= pix_backlog.pop_front();
            if (burst_left <= 1) begin
                burst_left <= $urandom_range(1, 24);
                idle_gap   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
                burst_left <= burst_left - 1;
            end
        end else begin
            i_valid <= 1'b0;
        end
    end

    // receiver stall pattern
    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(20, 300);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0: i_stall <= 1'b0;
            1: i_stall <= ($urandom_range(0, 3) == 0);
            2: i_stall <= ($urandom_range(0, 3) != 0);
            default: i_stall <= ((stall_left % 5) < 2);
        endcase
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pix_taken <= 1'b0;
        end else begin
            pix_taken <= i_valid && !o_stall;
            if (i_valid && !o_stall) begin
                rotated_due.push_back(hue_rotate(i_pixel));
                fed_cnt <= fed_cnt + 1;
            end
            if (o_valid && !i_stall) begin
                if (rotated_due.size() == 0) begin
                    note_mismatch("unexpected item, red", -1, int'(o_pixel.red_out));
                end else begin
                    due_pix = rotated_due.pop_front();
                    if (o_pixel.red_out !== due_pix.red_out) begin
                        note_mismatch("red_out", int'(due_pix.red_out), int'(o_pixel.red_out));
                    end
                    if (o_pixel.green_out !== due_pix.green_out) begin
                        note_mismatch("green_out", int'(due_pix.green_out),
                                      int'(o_pixel.green_out));
                    end
                    if (o_pixel.blue_out !== due_pix.blue_out) begin
                        note_mismatch("blue_out", int'(due_pix.blue_out),
                                      int'(o_pixel.blue_out));
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == RUN_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        logic [ANG_W-1:0] cos_set [8];
        logic [ANG_W-1:0] sin_set [8];
        cos_set = '{16'hC000, 16'h0000, 16'h0000, 16'h2D41, 16'h7FFF, 16'h8000,
                    16'h0000, 16'h4000};
        sin_set = '{16'h0000, 16'h4000, 16'hC000, 16'hD2BF, 16'h8000, 16'h7FFF,
                    16'h0000, 16'h0000};
        cos_set[6] = ANG_W'($urandom);
        sin_set[6] = ANG_W'($urandom);
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset angle: identity rotation
        queue_pixel(8'd0,   8'd0,   8'd0);
        queue_pixel(8'd255, 8'd255, 8'd255);
        queue_pixel(8'd255, 8'd0,   8'd0);
        queue_pixel(8'd0,   8'd255, 8'd0);
        queue_pixel(8'd0,   8'd0,   8'd255);
        queue_pixel(8'd255, 8'd255, 8'd0);
        queue_pixel(8'd0,   8'd255, 8'd255);
        queue_pixel(8'd255, 8'd0,   8'd255);
        queue_pixel(8'd128, 8'd128, 8'd128);
        queue_pixel(8'd127, 8'd127, 8'd127);
        queue_pixel(8'd85,  8'd170, 8'd85);
        queue_pixel(8'd170, 8'd85,  8'd170);
        queue_pixel(8'd1,   8'd254, 8'd1);
        queue_pixel(8'd254, 8'd1,   8'd254);
        queue_pixel(8'd0,   8'd0,   8'd1);
        queue_pixel(8'd255, 8'd255, 8'd254);
        for (int k = 0; k < PHASE_PIX; k++) begin
            pix_backlog.push_back(pick_pixel());
            queued_cnt++;
        end
        drain_pipe();

        for (int ph = 0; ph < 8; ph++) begin
            set_angle(REG_COS, cos_set[ph]);
            set_angle(REG_SIN, sin_set[ph]);
            for (int k = 0; k < PHASE_PIX; k++) begin
                pix_backlog.push_back(pick_pixel());
                queued_cnt++;
            end
            drain_pipe();
        end

        if (mismatch_cnt == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/yhr_pkg.sv
hdl/yhr_apb_regs.sv
hdl/yhr_to_yiq.sv
hdl/yhr_rotate.sv
hdl/yhr_to_rgb.sv
hdl/yiq_hue_rotate_pixel.sv
tb/sv/testbench.sv
